// File: sv/assert_macros.svh
// Assertion macros for the flat name directory.
// Used by the top level; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FNDT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FNDT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FNDT_ASSERT(label, clk, rst_n, prop, msg)
`define FNDT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: sv/fndt_pkg.sv
// Types and constants shared by the flat name directory modules.
// No dependencies.
package fndt_pkg;

	localparam int DEF_TABLE_ENTRIES = 32;
	localparam int DEF_NAME_BYTES    = 20;
	localparam int KEY_W             = 160;
	localparam int SLOT_W            = 6;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_LIST   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef struct packed {
		logic               key_load;
		logic               wr_en;
		logic               wr_from_key;
		logic               cnt_inc;
		logic               cnt_dec;
		logic               out_load;
		logic               out_name;
		logic               out_last;
		status_t            out_status;
		logic [SLOT_W-1:0]  out_slot;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t op;
		logic match;
		logic out_busy;
	} dp_stat_t;

endpackage

// File: sv/fndt_in_if.sv
// Request channel of the flat name directory: command and key item.
// No dependencies.
interface fndt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] key_bytes_lo;
	logic [63:0] key_bytes_mid;
	logic [31:0] key_bytes_hi;

	modport source (output valid, cmd, key_bytes_lo, key_bytes_mid, key_bytes_hi,
		input ready);
	modport sink (input valid, cmd, key_bytes_lo, key_bytes_mid, key_bytes_hi,
		output ready);
endinterface

// File: sv/fndt_out_if.sv
// Result channel of the flat name directory: status, slot and listed name.
// No dependencies.
interface fndt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  slot_number;
	logic [63:0] out_bytes_lo;
	logic [63:0] out_bytes_mid;
	logic [31:0] out_bytes_hi;
	logic        last_of_run;

	modport source (output valid, status, slot_number, out_bytes_lo, out_bytes_mid,
		out_bytes_hi, last_of_run, input ready);
	modport sink (input valid, status, slot_number, out_bytes_lo, out_bytes_mid,
		out_bytes_hi, last_of_run, output ready);
endinterface

// File: sv/fndt_dpath.sv
// Datapath: key register, name store memory, entry count and result register.
// Depends on fndt_pkg; driven by fndt_ctrl.
module fndt_dpath import fndt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int NAME_BYTES    = DEF_NAME_BYTES,
	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1),
	localparam int NAME_W = NAME_BYTES * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [IDX_W-1:0] rd_addr,
	input  logic [IDX_W-1:0] wr_addr,
	output dp_stat_t         stat,
	output logic [CNT_W-1:0] count,
	input  logic [1:0]       in_cmd,
	input  logic [63:0]      in_lo,
	input  logic [63:0]      in_mid,
	input  logic [31:0]      in_hi,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       out_status,
	output logic [5:0]       out_slot,
	output logic [63:0]      out_lo,
	output logic [63:0]      out_mid,
	output logic [31:0]      out_hi,
	output logic             out_last
);

	logic [KEY_W-1:0]  raw_key;
	logic [NAME_W-1:0] masked_key;
	logic [NAME_W-1:0] key_q;
	cmd_t              op_q;
	logic [NAME_W-1:0] mem_q [TABLE_ENTRIES];
	logic [NAME_W-1:0] rd_data_q;
	logic [NAME_W-1:0] wr_data;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic [KEY_W-1:0]  out_name_q;
	logic [2:0]        out_status_q;
	logic [5:0]        out_slot_q;
	logic              out_last_q;

	assign raw_key = {in_hi, in_mid, in_lo};

	// name ends at its first zero byte
	always_comb begin
		logic ended;
		ended = 1'b0;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (raw_key[b*8 +: 8] == 8'd0)
				ended = 1'b1;
			masked_key[b*8 +: 8] = ended ? 8'd0 : raw_key[b*8 +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			key_q <= masked_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= CMD_CREATE;
		end else if (cmd.key_load) begin
			op_q <= cmd_t'(in_cmd);
		end
	end

	assign wr_data = cmd.wr_from_key ? key_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_name_q   <= cmd.out_name ? KEY_W'(rd_data_q) : '0;
			out_status_q <= cmd.out_status;
			out_slot_q   <= cmd.out_slot;
			out_last_q   <= cmd.out_last;
		end
	end

	assign count         = count_q;
	assign stat.op       = op_q;
	assign stat.match    = (rd_data_q == key_q);
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_lo     = out_name_q[63:0];
	assign out_mid    = out_name_q[127:64];
	assign out_hi     = out_name_q[159:128];
	assign out_last   = out_last_q;

endmodule

// File: sv/fndt_ctrl.sv
// Controller: sequences the scan, move and list passes over the name store.
// Depends on fndt_pkg; drives fndt_dpath.
module fndt_ctrl import fndt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dp_stat_t         stat,
	input  logic [CNT_W-1:0] count,
	output dp_cmd_t          cmd,
	output logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] wr_addr
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_WR_NEW, S_RD, S_CMP, S_MV_RD, S_MV_WR, S_DEC,
		S_LS_RD, S_LS_OUT, S_EMIT
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	status_t           res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [CNT_W-1:0]  idx_p1;
	logic [CNT_W-1:0]  cnt_m1;
	logic              at_last;

	assign idx_p1  = CNT_W'(idx_q) + 1'b1;
	assign cnt_m1  = count - 1'b1;
	assign at_last = (idx_p1 == count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DISP;
				end
				S_DISP: begin
					idx_q      <= '0;
					res_slot_q <= '0;
					unique case (stat.op) inside
						CMD_CREATE: begin
							if (count >= CNT_W'(TABLE_ENTRIES)) begin
								res_status_q <= ST_FULL;
								state_q      <= S_EMIT;
							end else if (count == '0) begin
								state_q <= S_WR_NEW;
							end else begin
								state_q <= S_RD;
							end
						end
						CMD_DELETE, CMD_SEARCH: begin
							if (count == '0) begin
								res_status_q <= ST_NOT_FOUND;
								state_q      <= S_EMIT;
							end else begin
								state_q <= S_RD;
							end
						end
						CMD_LIST: begin
							if (count == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_EMIT;
							end else begin
								state_q <= S_LS_RD;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_WR_NEW: begin
					res_status_q <= ST_OK;
					state_q      <= S_EMIT;
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (stat.match) begin
						unique case (stat.op)
							CMD_CREATE: begin
								res_status_q <= ST_EXISTS;
								state_q      <= S_EMIT;
							end
							CMD_SEARCH: begin
								res_status_q <= ST_OK;
								res_slot_q   <= SLOT_W'(idx_p1);
								state_q      <= S_EMIT;
							end
							default: state_q <= at_last ? S_DEC : S_MV_RD;
						endcase
					end else if (at_last) begin
						if (stat.op == CMD_CREATE) begin
							state_q <= S_WR_NEW;
						end else begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_EMIT;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_MV_RD: state_q <= S_MV_WR;
				S_MV_WR: state_q <= S_DEC;
				S_DEC: begin
					res_status_q <= ST_OK;
					state_q      <= S_EMIT;
				end
				S_LS_RD: state_q <= S_LS_OUT;
				S_LS_OUT: begin
					if (!stat.out_busy) begin
						if (at_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_LS_RD;
						end
					end
				end
				S_EMIT: begin
					if (!stat.out_busy)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.out_status = ST_OK;
		rd_addr        = idx_q;
		wr_addr        = idx_q;
		unique case (state_q)
			S_IDLE: cmd.key_load = in_valid;
			S_WR_NEW: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_from_key = 1'b1;
				cmd.cnt_inc     = 1'b1;
				wr_addr         = count[IDX_W-1:0];
			end
			S_MV_RD: rd_addr = cnt_m1[IDX_W-1:0];
			S_MV_WR: cmd.wr_en = 1'b1;
			S_DEC: cmd.cnt_dec = 1'b1;
			S_LS_OUT: begin
				cmd.out_load = !stat.out_busy;
				cmd.out_name = 1'b1;
				cmd.out_last = at_last;
				cmd.out_slot = SLOT_W'(idx_p1);
			end
			S_EMIT: begin
				cmd.out_load   = !stat.out_busy;
				cmd.out_last   = 1'b1;
				cmd.out_status = res_status_q;
				cmd.out_slot   = res_slot_q;
			end
			default: ;
		endcase
	end

endmodule

// File: sv/flat_name_directory_table_top.sv
// Channel  Dir  Carries
// req      in   cmd, key_bytes_lo/mid/hi
// rsp      out  status, slot_number, out_bytes_lo/mid/hi, last_of_run
//
// Create, delete and search scan the name store through its single
// registered read port, reading and comparing each entry with the key.
// A create with no match appends the new name; a delete moves the last
// entry into the freed slot unless the match is the last entry.
// List reads and emits each entry in turn. arst_n clears the count and
// control; the store needs no clearing. A stalled rsp holds the controller.
// Top level of the flat name directory; depends on fndt_pkg, the channel
// interfaces, fndt_ctrl, fndt_dpath and assert_macros.svh.
`include "assert_macros.svh"
module flat_name_directory_table_top import fndt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int NAME_BYTES    = DEF_NAME_BYTES
) (
	input logic       clk,
	input logic       arst_n,
	fndt_in_if.sink   req,
	fndt_out_if.source rsp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [CNT_W-1:0] count;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;

	fndt_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.count    (count),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr)
	);

	fndt_dpath #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.NAME_BYTES   (NAME_BYTES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.stat       (stat),
		.count      (count),
		.in_cmd     (req.cmd),
		.in_lo      (req.key_bytes_lo),
		.in_mid     (req.key_bytes_mid),
		.in_hi      (req.key_bytes_hi),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_slot   (rsp.slot_number),
		.out_lo     (rsp.out_bytes_lo),
		.out_mid    (rsp.out_bytes_mid),
		.out_hi     (rsp.out_bytes_hi),
		.out_last   (rsp.last_of_run)
	);

	`FNDT_ASSERT_NEVER(a_count_range, clk, arst_n, count > CNT_W'(TABLE_ENTRIES), "count overflow")
	`FNDT_ASSERT_NEVER(a_inc_full, clk, arst_n, cmd.cnt_inc && (count >= CNT_W'(TABLE_ENTRIES)), "append to full table")
	`FNDT_ASSERT_NEVER(a_dec_empty, clk, arst_n, cmd.cnt_dec && (count == '0), "delete from empty table")
	`FNDT_ASSERT(a_busy_after_accept, clk, arst_n, (req.valid && req.ready) |=> !req.ready, "accepted twice")

endmodule

// File: tb/flat_name_directory_table_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for flat_name_directory_table_top: a queue-fed request driver,
// a response monitor and a behavioural model of the name table.
// Depends on fndt_pkg, fndt_in_if, fndt_out_if and the RTL.
module flat_name_directory_table_top_tb;
	import fndt_pkg::*;

	localparam int ENTRIES  = DEF_TABLE_ENTRIES;
	localparam int N_BYTES  = DEF_NAME_BYTES;
	localparam int POOL_SZ  = 48;
	localparam int N_RANDOM = 480;

	typedef struct {
		cmd_t         op;
		logic [159:0] key;
	} dir_req_t;

	typedef struct {
		status_t      status;
		logic [5:0]   slot;
		logic [159:0] name;
		logic         last;
	} dir_rsp_t;

	logic clk;
	logic arst_n;

	fndt_in_if  req_if ();
	fndt_out_if rsp_if ();

	flat_name_directory_table_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	dir_req_t     pending_reqs[$];
	dir_rsp_t     due_rsps[$];
	dir_req_t     cur_req;
	dir_req_t     next_req;
	logic [159:0] dir_names[ENTRIES];
	int           dir_count;
	int           fails;
	int           n_accepted;
	int           n_checked;
	int           n_lists;
	int           n_full_hits;
	int           peak_count;
	int           cyc;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// bytes past the first zero byte do not belong to the name
	function automatic logic [159:0] trim_name(logic [159:0] raw);
		logic [159:0] t;
		bit ended;
		t = '0;
		ended = 1'b0;
		for (int k = 0; k < N_BYTES; k++) begin
			if (raw[8*k +: 8] == 8'h00)
				ended = 1'b1;
			if (!ended)
				t[8*k +: 8] = raw[8*k +: 8];
		end
		return t;
	endfunction

	function automatic logic [159:0] add_tail(logic [159:0] n);
		logic [159:0] r;
		bit ended;
		r = n;
		ended = 1'b0;
		if ($urandom_range(1) == 1) begin
			for (int k = 0; k < N_BYTES; k++) begin
				if (ended)
					r[8*k +: 8] = 8'($urandom_range(255));
				else if (n[8*k +: 8] == 8'h00)
					ended = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [159:0] make_name();
		logic [159:0] n;
		int len;
		n = '0;
		len = ($urandom_range(99) < 60) ? $urandom_range(6, 1) : $urandom_range(20, 7);
		for (int k = 0; k < len; k++)
			n[8*k +: 8] = 8'($urandom_range(255, 1));
		return n;
	endfunction

	function automatic int find_name(logic [159:0] k);
		for (int i = 0; i < dir_count; i++)
			if (dir_names[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void push_rsp(status_t s, int slot, logic [159:0] n, logic last);
		dir_rsp_t r;
		r.status = s;
		r.slot   = 6'(slot);
		r.name   = n;
		r.last   = last;
		due_rsps.push_back(r);
	endfunction

	function automatic void predict_directory(dir_req_t r);
		logic [159:0] k;
		int pos;
		k = trim_name(r.key);
		pos = find_name(k);
		case (r.op)
			CMD_CREATE: begin
				if (dir_count >= ENTRIES) begin
					push_rsp(ST_FULL, 0, '0, 1'b1);
					n_full_hits++;
				end else if (pos >= 0) begin
					push_rsp(ST_EXISTS, 0, '0, 1'b1);
				end else begin
					dir_names[dir_count] = k;
					dir_count++;
					if (dir_count > peak_count)
						peak_count = dir_count;
					push_rsp(ST_OK, 0, '0, 1'b1);
				end
			end
			CMD_DELETE: begin
				if (pos < 0) begin
					push_rsp(ST_NOT_FOUND, 0, '0, 1'b1);
				end else begin
					dir_names[pos] = dir_names[dir_count-1];
					dir_count--;
					push_rsp(ST_OK, 0, '0, 1'b1);
				end
			end
			CMD_SEARCH: begin
				if (pos < 0)
					push_rsp(ST_NOT_FOUND, 0, '0, 1'b1);
				else
					push_rsp(ST_OK, pos + 1, '0, 1'b1);
			end
			default: begin
				n_lists++;
				if (dir_count == 0)
					push_rsp(ST_EMPTY, 0, '0, 1'b1);
				else
					for (int i = 0; i < dir_count; i++)
						push_rsp(ST_OK, i + 1, dir_names[i], i + 1 == dir_count);
			end
		endcase
	endfunction

	function automatic void queue_req(cmd_t op, logic [159:0] k);
		dir_req_t r;
		r.op  = op;
		r.key = k;
		pending_reqs.push_back(r);
	endfunction

	// no idling at all through a long window in the middle of the run
	function automatic bit take_break();
		return !(cyc >= 2000 && cyc < 5000) && $urandom_range(99) < 25;
	endfunction

	function automatic void check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", fname, exp_v, act_v);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cyc <= 0;
		else
			cyc <= cyc + 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid         <= 1'b0;
			req_if.cmd           <= CMD_CREATE;
			req_if.key_bytes_lo  <= '0;
			req_if.key_bytes_mid <= '0;
			req_if.key_bytes_hi  <= '0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				predict_directory(cur_req);
				n_accepted++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (pending_reqs.size() != 0 && !take_break()) begin
					next_req = pending_reqs.pop_front();
					cur_req  = next_req;
					req_if.valid         <= 1'b1;
					req_if.cmd           <= next_req.op;
					req_if.key_bytes_lo  <= next_req.key[63:0];
					req_if.key_bytes_mid <= next_req.key[127:64];
					req_if.key_bytes_hi  <= next_req.key[159:128];
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		dir_rsp_t e;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (due_rsps.size() == 0) begin
					$error("result item with nothing expected");
					fails++;
				end else begin
					e = due_rsps.pop_front();
					check_field("status", 64'(e.status), 64'(rsp_if.status));
					check_field("slot_number", 64'(e.slot), 64'(rsp_if.slot_number));
					check_field("out_bytes_lo", e.name[63:0], rsp_if.out_bytes_lo);
					check_field("out_bytes_mid", e.name[127:64], rsp_if.out_bytes_mid);
					check_field("out_bytes_hi", 64'(e.name[159:128]),
						64'(rsp_if.out_bytes_hi));
					check_field("last_of_run", 64'(e.last), 64'(rsp_if.last_of_run));
					n_checked++;
				end
			end
			rsp_if.ready <= !take_break();
		end
	end

	initial begin
		#5000000;
		$display("FAIL flat_name_directory_table_top");
		$finish;
	end

	initial begin
		logic [159:0] name_pool[POOL_SZ];
		logic [159:0] cand;
		logic [159:0] all_ff;
		logic [159:0] abc_tail1;
		logic [159:0] abc_tail2;
		logic [159:0] blank_tail;
		logic [159:0] one_byte;
		bit dup;
		int roll;
		int phase;
		int drain;
		cmd_t op;

		arst_n               = 1'b0;
		req_if.valid         = 1'b0;
		req_if.cmd           = CMD_CREATE;
		req_if.key_bytes_lo  = '0;
		req_if.key_bytes_mid = '0;
		req_if.key_bytes_hi  = '0;
		rsp_if.ready         = 1'b0;
		dir_count   = 0;
		fails       = 0;
		n_accepted  = 0;
		n_checked   = 0;
		n_lists     = 0;
		n_full_hits = 0;
		peak_count  = 0;

		all_ff     = '1;
		abc_tail1  = {{15{8'h00}}, 8'h5A, 32'h00636261};
		abc_tail2  = {{16{8'hFF}}, 32'h00636261};
		blank_tail = {{19{8'h3C}}, 8'h00};
		one_byte   = 160'h01;

		queue_req(CMD_LIST, '0);
		queue_req(CMD_SEARCH, all_ff);
		queue_req(CMD_DELETE, all_ff);
		queue_req(CMD_CREATE, '0);
		queue_req(CMD_CREATE, blank_tail);
		queue_req(CMD_CREATE, all_ff);
		queue_req(CMD_CREATE, abc_tail1);
		queue_req(CMD_CREATE, abc_tail2);
		queue_req(CMD_SEARCH, abc_tail2);
		queue_req(CMD_SEARCH, blank_tail);
		queue_req(CMD_SEARCH, all_ff);
		queue_req(CMD_CREATE, one_byte);
		queue_req(CMD_LIST, all_ff);
		queue_req(CMD_DELETE, blank_tail);
		queue_req(CMD_SEARCH, one_byte);
		queue_req(CMD_DELETE, abc_tail1);
		queue_req(CMD_LIST, '0);
		queue_req(CMD_DELETE, all_ff);
		queue_req(CMD_DELETE, one_byte);
		queue_req(CMD_DELETE, one_byte);
		queue_req(CMD_LIST, '0);

		// distinct names so that finds, duplicates and a full table all occur
		name_pool[0] = '0;
		for (int i = 1; i < POOL_SZ; i++) begin
			do begin
				cand = make_name();
				dup = 1'b0;
				for (int j = 0; j < i; j++)
					if (name_pool[j] == cand)
						dup = 1'b1;
			end while (dup);
			name_pool[i] = cand;
		end

		// cycle through growth, shrink, growth and balanced-mix phases
		for (int n = 0; n < N_RANDOM; n++) begin
			phase = (n / 80) % 4;
			roll = $urandom_range(99);
			case (phase) inside
				0, 2: op = roll < 65 ? CMD_CREATE : roll < 75 ? CMD_DELETE :
					roll < 90 ? CMD_SEARCH : CMD_LIST;
				1: op = roll < 15 ? CMD_CREATE : roll < 70 ? CMD_DELETE :
					roll < 90 ? CMD_SEARCH : CMD_LIST;
				default: op = roll < 35 ? CMD_CREATE : roll < 65 ? CMD_DELETE :
					roll < 90 ? CMD_SEARCH : CMD_LIST;
			endcase
			if ($urandom_range(99) < 85)
				cand = name_pool[$urandom_range(POOL_SZ - 1)];
			else
				cand = make_name();
			queue_req(op, add_tail(cand));
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_if.valid)
			@(posedge clk);
		drain = 0;
		while (due_rsps.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (100) @(posedge clk);
		if (due_rsps.size() != 0) begin
			$error("%0d result items never arrived", due_rsps.size());
			fails++;
		end

		$display("Run covered %0d requests and %0d checked result items, %0d of them lists.",
			n_accepted, n_checked, n_lists);
		$display("Table peaked at %0d names; %0d creates met a full table.",
			peak_count, n_full_hits);
		if (fails == 0)
			$display("PASS flat_name_directory_table_top");
		else
			$display("FAIL flat_name_directory_table_top");
		$finish;
	end

endmodule
